>>> hdl/bbec_pkg.sv
// shared types, constants and the reciprocal table of the 3x3 box blur
package bbec_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd768;

    localparam int CH_W   = 8;
    localparam int NUM_CH = 3;
    localparam int PIX_W  = CH_W * NUM_CH;
    localparam int SUM_W  = 12;               // 9 * 255 fits
    localparam int CNT_W  = 4;                // 1 to 9
    localparam int NUM_W  = SUM_W + 1;        // 2*sum + count
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // neighborhood clipping and item flags, captured when an item is taken
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic frame_end;
        logic emit;
        logic drain;
    } pos_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic wr;
        logic sum;
        logic mul;
        logic out_load;
        pos_t pos;
    } cmd_t;

    // ceil(2^18 / (2*count)); exact floor division for numerators below 2^13
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd5:    m = 18'd26215;
            4'd6:    m = 18'd21846;
            4'd7:    m = 18'd18725;
            4'd8:    m = 18'd16384;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hdl/bbec_ctrl.sv
// sequencer: config registers, raster position counters and item state machine
module bbec_ctrl #(
    parameter int MAX_WIDTH  = bbec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbec_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [bbec_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bbec_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_op,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bbec_pkg::cmd_t                      cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]        addr
);
    import bbec_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int CWW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int CHW = (RW > HEIGHT_REG_W) ? RW : HEIGHT_REG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [AW-1:0]           ic_reg, ic_next;
    logic [RW-1:0]           ir_reg, ir_next;
    logic [AW-1:0]           ocol_reg, ocol_next;
    logic [RW-1:0]           orow_reg, orow_next;
    logic [AW-1:0]           addr_reg, addr_next;
    pos_t                    pos_reg, pos_next;
    logic                    out_valid_reg, out_valid_next;

    logic [CWW-1:0] w_ext;
    logic [CHW-1:0] h_ext;
    logic [WW-1:0]  w_eff;
    logic [RW-1:0]  h_eff;
    logic           accept;
    logic           draining;
    logic           ignore;
    logic           emit;
    logic           col_wrap;
    logic           out_wrap;
    logic           fe;
    logic           out_load;

    // clamp the register values to 1..max
    always_comb
    begin
        w_ext = CWW'(width_reg);
        h_ext = CHW'(height_reg);
        if (w_ext == '0)
            w_eff = WW'(1);
        else if (w_ext > CWW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(w_ext);
        if (h_ext == '0)
            h_eff = RW'(1);
        else if (h_ext > CHW'(MAX_HEIGHT))
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(h_ext);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign draining = (ir_reg >= h_eff);
    assign ignore   = !draining && in_op;
    assign emit     = (ir_reg >= RW'(2)) || ((ir_reg == RW'(1)) && (ic_reg != '0));
    assign col_wrap = ((WW'(ic_reg) + WW'(1)) >= w_eff);
    assign out_wrap = ((WW'(ocol_reg) + WW'(1)) >= w_eff);
    assign fe       = (orow_reg == (h_eff - RW'(1))) && (WW'(ocol_reg) == (w_eff - WW'(1)));

    always_comb
    begin
        state_next  = state_reg;
        width_next  = width_reg;
        height_next = height_reg;
        ic_next     = ic_reg;
        ir_next     = ir_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        out_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // a drain item while pixels are still due is dropped
                if (accept && !ignore)
                begin
                    state_next         = S_READ;
                    addr_next          = ic_reg;
                    pos_next.top_ok    = (orow_reg != '0);
                    pos_next.bot_ok    = ((orow_reg + RW'(1)) < h_eff);
                    pos_next.left_ok   = (ocol_reg != '0);
                    pos_next.right_ok  = !out_wrap;
                    pos_next.frame_end = fe;
                    pos_next.emit      = emit;
                    pos_next.drain     = draining;
                    if (col_wrap)
                    begin
                        ic_next = '0;
                        ir_next = ir_reg + RW'(1);
                    end
                    else
                    begin
                        ic_next = ic_reg + AW'(1);
                    end
                    if (emit)
                    begin
                        if (out_wrap)
                        begin
                            ocol_next = '0;
                            orow_next = orow_reg + RW'(1);
                        end
                        else
                        begin
                            ocol_next = ocol_reg + AW'(1);
                        end
                        if (fe)
                        begin
                            ic_next   = '0;
                            ir_next   = '0;
                            ocol_next = '0;
                            orow_next = '0;
                        end
                    end
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = pos_reg.emit ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any register write restarts the frame
        if (cfg_wen)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
                width_next = cfg_data[WIDTH_REG_W-1:0];
            else
                height_next = cfg_data[HEIGHT_REG_W-1:0];
            ic_next   = '0;
            ir_next   = '0;
            ocol_next = '0;
            orow_next = '0;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            ic_reg        <= '0;
            ir_reg        <= '0;
            ocol_reg      <= '0;
            orow_reg      <= '0;
            addr_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            ic_reg        <= ic_next;
            ir_reg        <= ir_next;
            ocol_reg      <= ocol_next;
            orow_reg      <= orow_next;
            addr_reg      <= addr_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign addr         = addr_reg;
    assign cmd.load     = accept;
    assign cmd.rd       = (state_reg == S_READ);
    assign cmd.wr       = (state_reg == S_WRITE);
    assign cmd.sum      = (state_reg == S_SUM);
    assign cmd.mul      = (state_reg == S_MUL);
    assign cmd.out_load = out_load;
    assign cmd.pos      = pos_reg;

endmodule

>>> hdl/bbec_dp.sv
// datapath: line buffers, 3x3 window, clipped sums, reciprocal divide, output register
module bbec_dp #(
    parameter int MAX_WIDTH = bbec_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  bbec_pkg::cmd_t                  cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]    addr,
    input  logic [bbec_pkg::PIX_W-1:0]      in_data,
    output logic [bbec_pkg::PIX_W-1:0]      out_data,
    output logic                            out_last
);
    import bbec_pkg::*;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [PIX_W-1:0]  pix_reg;
    logic [PIX_W-1:0]  up_rd_reg;
    logic [PIX_W-1:0]  mid_rd_reg;
    logic [PIX_W-1:0]  win_reg [3][3];
    logic [SUM_W-1:0]  sum_reg [NUM_CH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W-1:0] prod_reg [NUM_CH];
    logic [PIX_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic [PIX_W-1:0]  pix_use;
    logic [2:0]        row_ok;
    logic [2:0]        col_ok;
    logic [1:0]        rv;
    logic [1:0]        cv;
    logic [CNT_W-1:0]  cnt_comb;
    logic [SUM_W-1:0]  sum_comb [NUM_CH];
    logic [NUM_W-1:0]  num [NUM_CH];
    logic [RECIP_W-1:0] recip;

    // a drained position stores black
    assign pix_use = cmd.pos.drain ? '0 : pix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pix_reg <= in_data;
    end

    // read the column first, write it back in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            up_rd_reg  <= upper_mem[addr];
            mid_rd_reg <= middle_mem[addr];
        end
        if (cmd.wr)
        begin
            upper_mem[addr]  <= mid_rd_reg;
            middle_mem[addr] <= pix_use;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_rd_reg;
            win_reg[1][2] <= mid_rd_reg;
            win_reg[2][2] <= pix_use;
        end
    end

    always_comb
    begin
        row_ok   = {cmd.pos.bot_ok, 1'b1, cmd.pos.top_ok};
        col_ok   = {cmd.pos.right_ok, 1'b1, cmd.pos.left_ok};
        rv       = 2'd1 + {1'b0, cmd.pos.top_ok} + {1'b0, cmd.pos.bot_ok};
        cv       = 2'd1 + {1'b0, cmd.pos.left_ok} + {1'b0, cmd.pos.right_ok};
        cnt_comb = {2'b00, rv} * {2'b00, cv};
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum_comb[ch] = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (row_ok[r] && col_ok[c])
                        sum_comb[ch] = sum_comb[ch] + SUM_W'(win_reg[r][c][ch*CH_W +: CH_W]);
                end
            end
        end
    end

    // half-up rounding: (2*sum + count) / (2*count) by reciprocal multiply
    always_comb
    begin
        recip = recip_lookup(cnt_reg);
        for (int ch = 0; ch < NUM_CH; ch++)
            num[ch] = {sum_reg[ch], 1'b0} + NUM_W'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg <= sum_comb;
            cnt_reg <= cnt_comb;
        end
        if (cmd.mul)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
                prod_reg[ch] <= PROD_W'(num[ch]) * PROD_W'(recip);
        end
        if (cmd.out_load)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
                out_data_reg[ch*CH_W +: CH_W] <= prod_reg[ch][RECIP_SHIFT +: CH_W];
            out_last_reg <= cmd.pos.frame_end;
        end
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

>>> hdl/box_blur_3x3_edge_clipped_core.sv
// 3x3 box blur with edge clipping over an rgb pixel stream
//
// pixels enter in raster order on the s_axis channel; tuser set marks a drain item.
// after the last pixel of a frame the sender supplies width+1 drain items.
// output k leaves on m_axis after input item k+width+1; tlast marks the
// bottom-right pixel, after which a new frame starts. each color is the
// half-up rounded mean of the in-image part of its 3x3 neighborhood.
// one item at a time runs through the sequencer: read the line buffers,
// write them back and shift the window, sum, multiply by the reciprocal of
// twice the count, load the output register. an item without a result
// returns to idle after the write-back, and a drain item while pixels are
// still due is dropped without leaving idle. a new item is taken only once
// the sequencer is back in idle. a waiting result does not block
// acceptance; a following result waits until the receiver takes it.
// reset sets width 1024 and height 768 and starts at the top-left pixel;
// a register write restarts the frame. line buffer contents need no reset.
module box_blur_3x3_edge_clipped_core #(
    parameter int MAX_WIDTH  = bbec_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bbec_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [bbec_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bbec_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bbec_pkg::PIX_W-1:0]        s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                              s_axis_tuser,   // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bbec_pkg::PIX_W-1:0]        m_axis_tdata,   // red_out, green_out, blue_out
    output logic                              m_axis_tlast
);
    import bbec_pkg::*;

    cmd_t                         cmd;
    logic [$clog2(MAX_WIDTH)-1:0] addr;

    bbec_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .addr      (addr)
    );

    bbec_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .addr     (addr),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule

>>> tb/testbench.sv
// self-checking testbench for the 3x3 edge-clipped box blur core
module testbench;

    import bbec_pkg::*;

    localparam int LINE_MAX      = MAX_WIDTH_DEF;
    localparam int ROWS_MAX      = MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRINT_CAP     = 50;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] rgb;
        logic             last;
    } blur_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIX_W-1:0]       s_axis_tdata = '0;   // red_in, green_in, blue_in
    logic                   s_axis_tuser = 1'b0; // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIX_W-1:0]       m_axis_tdata;        // red_out, green_out, blue_out
    logic                   m_axis_tlast;        // frame_end

    box_blur_3x3_edge_clipped_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [PIX_W-1:0]        upper_line [LINE_MAX];
    logic [PIX_W-1:0]        middle_line [LINE_MAX];
    logic [PIX_W-1:0]        win [3][3];
    int                      in_row, in_col, out_row, out_col;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;

    blur_result_t blurred_q [$];
    string        chan_names [3] = '{"red", "green", "blue"};

    int error_count = 0;
    int items_taken = 0;
    int results_seen = 0;
    int frames_done = 0;
    int stim_count = 0;
    int cycle_count = 0;

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_on = 1'b0;
    int   hold_cnt = 0;

    // effective frame size as the stimulus sees it
    int frame_w = 1024;
    int frame_h = 768;

    function automatic int dim_clamp(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void clear_positions();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic void blur_reset();
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        clear_positions();
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = data[WIDTH_REG_W-1:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = data[HEIGHT_REG_W-1:0];
        clear_positions();
    endfunction

    // clipped mean around (orow, ocol); the center sits in window column cc
    function automatic logic [PIX_W-1:0] neighborhood_mean(input int cc, input int orow,
                                                          input int ocol, input int w,
                                                          input int h);
        int               sum [3];
        int               cnt;
        int               r, c, wc;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] m;
        sum = '{0, 0, 0};
        cnt = 0;
        m = '0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            r = orow + dr;
            if (r < 0 || r >= h)
                continue;
            for (int dc = -1; dc <= 1; dc++)
            begin
                c = ocol + dc;
                wc = cc + dc;
                if (c < 0 || c >= w || wc < 0 || wc > 2)
                    continue;
                px = win[dr + 1][wc];
                for (int ch = 0; ch < 3; ch++)
                    sum[ch] += px[ch*CH_W +: CH_W];
                cnt++;
            end
        end
        for (int ch = 0; ch < 3; ch++)
            if (cnt != 0)
                m[ch*CH_W +: CH_W] = CH_W'((2 * sum[ch] + cnt) / (2 * cnt));
        return m;
    endfunction

    function automatic bit blur_step(input logic op, input logic [PIX_W-1:0] rgb,
                                     output blur_result_t res);
        int               w, h, ir, ic;
        bit               draining, emit, fe;
        logic [PIX_W-1:0] pix, up, mid, mean;
        w = dim_clamp(int'(width_reg), LINE_MAX);
        h = dim_clamp(int'(height_reg), ROWS_MAX);
        ir = in_row;
        ic = in_col;
        draining = (ir >= h);
        res = '0;
        mean = '0;
        if (!draining && op == OP_DRAIN)
            return 1'b0;
        pix = draining ? '0 : rgb;
        emit = (ir >= 2) || (ir == 1 && ic >= 1);
        // a row's last output uses the window before the next column shifts in
        if (emit && ic == 0)
            mean = neighborhood_mean(2, out_row, out_col, w, h);
        up = upper_line[ic];
        mid = middle_line[ic];
        upper_line[ic] = mid;
        middle_line[ic] = pix;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;
        if (emit && ic != 0)
            mean = neighborhood_mean(1, out_row, out_col, w, h);
        if (ic + 1 >= w)
        begin
            in_col = 0;
            in_row = ir + 1;
        end
        else
            in_col = ic + 1;
        if (!emit)
            return 1'b0;
        fe = (out_row == h - 1) && (out_col == w - 1);
        res.rgb = mean;
        res.last = fe;
        if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        if (fe)
            clear_positions();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        if (error_count < PRINT_CAP)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    // predict on accepted items, check accepted results
    always @(posedge clk)
    begin : check_results
        blur_result_t made;
        blur_result_t want;
        if (rst_n)
        begin
            if (cfg_wen)
                apply_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_taken++;
                if (blur_step(s_axis_tuser, s_axis_tdata, made))
                    blurred_q.push_back(made);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tlast)
                    frames_done++;
                if (blurred_q.size() == 0)
                begin
                    if (error_count < PRINT_CAP)
                        $display("%0t: result with none expected: expected nothing, actual %06h last %0b",
                                 $time, m_axis_tdata, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    for (int ch = 0; ch < 3; ch++)
                        if (m_axis_tdata[ch*CH_W +: CH_W] !== want.rgb[ch*CH_W +: CH_W])
                            report_mismatch(chan_names[ch], want.rgb[ch*CH_W +: CH_W],
                                            m_axis_tdata[ch*CH_W +: CH_W]);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("frame_end", want.last, m_axis_tlast);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold counted here
    always @(posedge clk)
    begin
        if (!hold_on)
            hold_cnt <= 0;
        else if (hold_cnt < HOLD_CYCLES)
            hold_cnt <= hold_cnt + 1;
        if (hold_on && hold_cnt < HOLD_CYCLES)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, blurred_q.size());
            $display("FAIL box_blur_3x3_edge_clipped_core");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        for (int ch = 0; ch < 3; ch++)
            case ($urandom_range(7))
                0:       p[ch*CH_W +: CH_W] = 8'h00;
                1:       p[ch*CH_W +: CH_W] = 8'hFF;
                default: p[ch*CH_W +: CH_W] = CH_W'($urandom);
            endcase
        return p;
    endfunction

    task automatic send_item(input logic op, input logic [PIX_W-1:0] rgb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= rgb;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // pixels in raster order, with stray drain items mixed in
    task automatic send_pixels(input int n, input int noise_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(OP_DRAIN, PIX_W'($urandom));
            send_item(OP_PIXEL, rand_pixel());
            stim_count++;
        end
    endtask

    // flush items; a pixel item here only acts as a drain
    task automatic send_drains(input int n, input int pixel_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < pixel_pct)
                send_item(OP_PIXEL, rand_pixel());
            else
                send_item(OP_DRAIN, PIX_W'($urandom));
            stim_count++;
        end
    endtask

    task automatic send_frame(input int noise_pct, input int pixel_pct);
        send_pixels(frame_w * frame_h, noise_pct);
        send_drains(frame_w + 1, pixel_pct);
    endtask

    // wait until the core is idle before a register write
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (blurred_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            frame_w = dim_clamp(int'(value[WIDTH_REG_W-1:0]), LINE_MAX);
        else
            frame_h = dim_clamp(int'(value[HEIGHT_REG_W-1:0]), ROWS_MAX);
        @(posedge clk);
    endtask

    task automatic set_size(input int w, input int h);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    task automatic set_idle(input int sender, input int receiver);
        send_idle_pct = sender;
        stall_pct = receiver;
    endtask

    // reset width keeps a short run silent, then one column under the reset height
    task automatic test_reset_sizes();
        set_idle(11, 11);
        send_pixels(150, 0);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
        send_pixels(30, 0);
    endtask

    task automatic test_directed();
        logic [PIX_W-1:0] pattern [9];
        pattern = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'hFF00FF, 24'h563412,
                    24'hFFFFFF, 24'h00FF00, 24'h0000FF, 24'h000000};
        set_idle(0, 0);
        set_size(3, 3);
        for (int i = 0; i < 9; i++)
        begin
            // drain item while pixels are still due must be ignored
            if (i == 4)
                send_item(OP_DRAIN, 24'hFFFFFF);
            send_item(OP_PIXEL, pattern[i]);
        end
        send_item(OP_DRAIN, 24'h000000);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_DRAIN, 24'hFFFFFF);
        send_item(OP_DRAIN, 24'h000000);
        // zero sizes act as one
        set_size(0, 0);
        send_item(OP_PIXEL, 24'hFFFFFF);
        send_item(OP_DRAIN, 24'h000000);
        send_item(OP_PIXEL, 24'h000000);
        // two back-to-back frames of one row
        set_size(2, 1);
        send_frame(0, 0);
        send_frame(0, 0);
    endtask

    // values above the maximum saturate
    task automatic test_size_limits();
        set_idle(11, 11);
        set_size(2047, 1);
        send_pixels(60, 0);
        set_size(1, 8191);
        send_pixels(40, 0);
    endtask

    task automatic test_back_pressure();
        set_idle(0, 0);
        set_size(5, 4);
        hold_on <= 1'b1;
        send_frame(0, 0);
        settle();
        hold_on <= 1'b0;
    endtask

    task automatic pick_random_size();
        logic [1:0] spare;
        spare = 2'($urandom);
        settle();
        write_reg(REG_IMAGE_WIDTH, {spare, WIDTH_REG_W'($urandom_range(8))});
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(6)));
    endtask

    task automatic test_random_frames(input int sender, input int receiver, input int quota);
        int start;
        int n;
        set_idle(sender, receiver);
        start = stim_count;
        pick_random_size();
        while (stim_count - start < quota)
        begin
            if ($urandom_range(7) == 0)
            begin
                // frame cut short by a register write
                n = $urandom_range(frame_w * frame_h + frame_w, 1);
                if (n <= frame_w * frame_h)
                    send_pixels(n, 6);
                else
                begin
                    send_pixels(frame_w * frame_h, 6);
                    send_drains(n - frame_w * frame_h, 20);
                end
                pick_random_size();
            end
            else
            begin
                send_frame(6, 20);
                if ($urandom_range(2) == 0)
                    pick_random_size();
            end
        end
    endtask

    initial
    begin
        blur_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_sizes();
        test_directed();
        test_size_limits();
        test_back_pressure();
        test_random_frames(0, 0, 140);
        test_random_frames(76, 0, 140);
        test_random_frames(0, 76, 140);
        test_random_frames(11, 11, 140);

        settle();
        if (blurred_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, blurred_q.size());
            error_count++;
        end
        $display("covered %0d items taken, %0d results checked, %0d complete frames",
                 items_taken, results_seen, frames_done);
        $display("sizes 1x1 to 1024 wide and 4096 high, four idle mixes and a long output hold");
        if (error_count == 0)
            $display("PASS box_blur_3x3_edge_clipped_core");
        else
            $display("FAIL box_blur_3x3_edge_clipped_core");
        $finish;
    end

endmodule
